@@ src/bsfe_pkg.sv @@
// ----------------------------------------------------------------------------
// bsfe_pkg
// Shared constants and types of the byte-stuffed frame encoder.
// ----------------------------------------------------------------------------
package bsfe_pkg;

  // Frame store depth. An escaped payload that reaches this length is dropped.
  localparam int FRAME_BUF_LEN = 48;

  localparam int BYTE_W = 8;
  localparam int IDX_W  = $clog2(FRAME_BUF_LEN);
  localparam int CNT_W  = $clog2(FRAME_BUF_LEN + 1);

  // Configuration register indexes.
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_HEADER = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FOOTER = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ESCAPE = 2'd2;

  // Register reset values.
  localparam logic [BYTE_W-1:0] HEADER_RST = 8'd237;
  localparam logic [BYTE_W-1:0] FOOTER_RST = 8'd238;
  localparam logic [BYTE_W-1:0] ESCAPE_RST = 8'd233;

  // Control from the sequencer to the frame store.
  typedef struct packed {
    logic              wr_en;
    logic [BYTE_W-1:0] wr_byte;
    logic              clear;
    logic [IDX_W-1:0]  rd_addr;
  } store_ctl_t;

  // Status from the frame store to the sequencer.
  typedef struct packed {
    logic [CNT_W-1:0]  count;
    logic [BYTE_W-1:0] sum;
    logic              overflow;
    logic [BYTE_W-1:0] rd_data;
  } store_sts_t;

endpackage

@@ src/bsfe_store.sv @@
// ----------------------------------------------------------------------------
// bsfe_store
// Frame store: escaped byte memory, fill count, running checksum adder and
// overflow flag. One byte is appended per write request; reads are registered.
// ----------------------------------------------------------------------------
module bsfe_store
  import bsfe_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  store_ctl_t ctl,
  output store_sts_t sts
);

  logic [BYTE_W-1:0] mem [FRAME_BUF_LEN];
  logic [BYTE_W-1:0] rd_data_r;

  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [BYTE_W-1:0] sum_r, sum_nxt;
  logic              overflow_r, overflow_nxt;
  logic              has_room;

  assign has_room = (count_r < CNT_W'(FRAME_BUF_LEN));

  // Append logic: the count saturates at the store depth, the sum always adds.
  always_comb begin
    count_nxt    = count_r;
    sum_nxt      = sum_r;
    overflow_nxt = overflow_r;
    if (ctl.clear) begin
      count_nxt    = '0;
      sum_nxt      = '0;
      overflow_nxt = 1'b0;
    end else if (ctl.wr_en) begin
      if (has_room) begin
        count_nxt = count_r + CNT_W'(1);
      end
      sum_nxt = sum_r + ctl.wr_byte;
      if (count_nxt >= CNT_W'(FRAME_BUF_LEN)) begin
        overflow_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r    <= '0;
      sum_r      <= '0;
      overflow_r <= 1'b0;
    end else begin
      count_r    <= count_nxt;
      sum_r      <= sum_nxt;
      overflow_r <= overflow_nxt;
    end
  end

  // Memory write at the fill position, registered read.
  always_ff @(posedge clk) begin
    if (ctl.wr_en && !ctl.clear && has_room) begin
      mem[count_r[IDX_W-1:0]] <= ctl.wr_byte;
    end
    rd_data_r <= mem[ctl.rd_addr];
  end

  assign sts.count    = count_r;
  assign sts.sum      = sum_r;
  assign sts.overflow = overflow_r;
  assign sts.rd_data  = rd_data_r;

endmodule

@@ src/byte_stuffed_frame_encoder.sv @@
// ----------------------------------------------------------------------------
// byte_stuffed_frame_encoder
// Byte-stuffing framer with an 8-bit additive checksum.
// ----------------------------------------------------------------------------
// Payload bytes enter one request at a time; a byte equal to the header,
// footer or escape value is stored behind an escape byte, and every stored
// byte goes through a single checksum adder and a single store write port,
// one byte per cycle. A plain byte is written in the data state, an escaped
// byte in the escape and then the data state, while in_tready is low. On the
// item marked tlast the block checks for overflow in a check state and then
// sends the frame (header, length, escaped payload, checksum, footer) at one
// byte per cycle while the sink is ready, or one too_long request if the
// escaped length reached FRAME_BUF_LEN. The next item is taken after the
// footer or abort request has been loaded into the output register.
module byte_stuffed_frame_encoder
  import bsfe_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  // Configuration write port.
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [BYTE_W-1:0]    cfg_wdata,
  // Payload input.
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [7:0]           in_tdata,   // [7:0] payload_byte
  input  logic                 in_tuser,   // [0] has_byte
  input  logic                 in_tlast,   // end_of_payload
  // Frame output.
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output logic [7:0]           out_tdata,  // [7:0] frame_byte
  output logic                 out_tuser,  // [0] too_long
  output logic                 out_tlast   // frame_end
);

  localparam int ST_W = 4;
  localparam logic [ST_W-1:0] ST_IDLE  = 4'd0;
  localparam logic [ST_W-1:0] ST_ESC   = 4'd1;
  localparam logic [ST_W-1:0] ST_DATA  = 4'd2;
  localparam logic [ST_W-1:0] ST_CHECK = 4'd3;
  localparam logic [ST_W-1:0] ST_ABORT = 4'd4;
  localparam logic [ST_W-1:0] ST_HDR   = 4'd5;
  localparam logic [ST_W-1:0] ST_LEN   = 4'd6;
  localparam logic [ST_W-1:0] ST_PAY   = 4'd7;
  localparam logic [ST_W-1:0] ST_SUM   = 4'd8;
  localparam logic [ST_W-1:0] ST_FTR   = 4'd9;

  logic [ST_W-1:0]   state_r, state_nxt;
  logic [BYTE_W-1:0] header_r, footer_r, escape_r;
  logic [BYTE_W-1:0] byte_r;
  logic              last_r;
  logic [IDX_W-1:0]  idx_r, idx_nxt;

  logic              out_valid_r, out_end_r, out_long_r;
  logic [BYTE_W-1:0] out_byte_r;
  logic              push, push_end, push_long;
  logic [BYTE_W-1:0] push_byte;
  logic              out_free;
  logic              in_acc;
  logic              special;
  logic              pay_done;

  store_ctl_t        ctl;
  store_sts_t        sts;

  bsfe_store u_store (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (ctl),
    .sts   (sts)
  );

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      header_r <= HEADER_RST;
      footer_r <= FOOTER_RST;
      escape_r <= ESCAPE_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_HEADER: header_r <= cfg_wdata;
        CFG_FOOTER: footer_r <= cfg_wdata;
        CFG_ESCAPE: escape_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign in_tready = (state_r == ST_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign special   = (in_tdata == header_r) || (in_tdata == footer_r) ||
                     (in_tdata == escape_r);
  assign out_free  = !out_valid_r || out_tready;
  assign pay_done  = ({1'b0, idx_r} + (IDX_W+1)'(1)) == (IDX_W+1)'(sts.count);

  // Sequencer: stores bytes through the frame store, then walks the frame.
  always_comb begin
    state_nxt   = state_r;
    idx_nxt     = idx_r;
    ctl.wr_en   = 1'b0;
    ctl.wr_byte = byte_r;
    ctl.clear   = 1'b0;
    ctl.rd_addr = idx_r;
    push        = 1'b0;
    push_byte   = '0;
    push_end    = 1'b0;
    push_long   = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          if (in_tuser && special) begin
            state_nxt = ST_ESC;
          end else if (in_tuser) begin
            state_nxt = ST_DATA;
          end else if (in_tlast) begin
            state_nxt = ST_CHECK;
          end
        end
      end
      ST_ESC: begin
        ctl.wr_en   = 1'b1;
        ctl.wr_byte = escape_r;
        state_nxt   = ST_DATA;
      end
      ST_DATA: begin
        ctl.wr_en = 1'b1;
        state_nxt = last_r ? ST_CHECK : ST_IDLE;
      end
      ST_CHECK: begin
        idx_nxt   = '0;
        state_nxt = sts.overflow ? ST_ABORT : ST_HDR;
      end
      ST_ABORT: begin
        if (out_free) begin
          push      = 1'b1;
          push_end  = 1'b1;
          push_long = 1'b1;
          ctl.clear = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      ST_HDR: begin
        if (out_free) begin
          push      = 1'b1;
          push_byte = header_r;
          state_nxt = ST_LEN;
        end
      end
      ST_LEN: begin
        if (out_free) begin
          push      = 1'b1;
          push_byte = BYTE_W'(sts.count);
          state_nxt = (sts.count == '0) ? ST_SUM : ST_PAY;
        end
      end
      ST_PAY: begin
        if (out_free) begin
          push      = 1'b1;
          push_byte = sts.rd_data;
          if (pay_done) begin
            state_nxt = ST_SUM;
          end else begin
            // Read ahead so the next entry is ready on the following cycle.
            idx_nxt     = idx_r + IDX_W'(1);
            ctl.rd_addr = idx_nxt;
          end
        end
      end
      ST_SUM: begin
        if (out_free) begin
          push      = 1'b1;
          push_byte = sts.sum;
          state_nxt = ST_FTR;
        end
      end
      ST_FTR: begin
        if (out_free) begin
          push      = 1'b1;
          push_byte = footer_r;
          push_end  = 1'b1;
          ctl.clear = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      idx_r   <= '0;
    end else begin
      state_r <= state_nxt;
      idx_r   <= idx_nxt;
    end
  end

  // Input item capture.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      byte_r <= in_tdata;
      last_r <= in_tlast;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (push) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      out_byte_r <= push_byte;
      out_end_r  <= push_end;
      out_long_r <= push_long;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_byte_r;
  assign out_tlast  = out_end_r;
  assign out_tuser  = out_long_r;

endmodule

@@ tb/sv/bsfe_frame_checker.sv @@
// ----------------------------------------------------------------------------
// bsfe_frame_checker
// Watches the byte-stuffed frame encoder and checks every frame byte it sends.
// ----------------------------------------------------------------------------
// The checker follows the configuration port and the payload channel, keeps
// its own copy of the escaped store, the length, the checksum and the
// overflow flag, and queues the frame bytes that each accepted request must
// produce. Each request taken on the frame channel is compared field by
// field with the oldest queued byte. The number of failures and the number
// of bytes still awaited are handed to the testbench top.
module bsfe_frame_checker
  import bsfe_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [BYTE_W-1:0]    cfg_wdata,
  input  logic                 in_tvalid,
  input  logic                 in_tready,
  input  logic [7:0]           in_tdata,   // [7:0] payload_byte
  input  logic                 in_tuser,   // [0] has_byte
  input  logic                 in_tlast,   // end_of_payload
  input  logic                 out_tvalid,
  input  logic                 out_tready,
  input  logic [7:0]           out_tdata,  // [7:0] frame_byte
  input  logic                 out_tuser,  // [0] too_long
  input  logic                 out_tlast,  // frame_end
  output int                   fail_count,
  output int                   pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [BYTE_W-1:0] frame_byte;
    logic              frame_end;
    logic              too_long;
  } frame_byte_t;

  // Shadow of the configuration registers.
  logic [BYTE_W-1:0] hdr_val;
  logic [BYTE_W-1:0] ftr_val;
  logic [BYTE_W-1:0] esc_val;

  // Shadow of the frame under construction.
  logic [BYTE_W-1:0] stuffed_bytes [FRAME_BUF_LEN];
  logic [CNT_W-1:0]  stuffed_len;
  logic [BYTE_W-1:0] byte_sum;
  logic              frame_dropped;

  frame_byte_t frame_expect_q [$];

  // Store one escaped byte; bytes past the buffer only feed the checksum.
  function automatic void stuff_byte(logic [BYTE_W-1:0] b);
    if (stuffed_len < FRAME_BUF_LEN) begin
      stuffed_bytes[stuffed_len] = b;
      stuffed_len = stuffed_len + 1'b1;
    end
    byte_sum = byte_sum + b;
    if (stuffed_len >= FRAME_BUF_LEN) begin
      frame_dropped = 1'b1;
    end
  endfunction

  function automatic void queue_byte(logic [BYTE_W-1:0] b, logic fe, logic tl);
    frame_byte_t r;
    r.frame_byte = b;
    r.frame_end  = fe;
    r.too_long   = tl;
    frame_expect_q.push_back(r);
  endfunction

  function automatic void clear_frame();
    stuffed_len   = '0;
    byte_sum      = '0;
    frame_dropped = 1'b0;
  endfunction

  // Escape the payload byte and, on the last request, queue the whole frame.
  function automatic void encode_payload(logic [7:0] b, logic has_byte, logic last);
    int i;
    if (has_byte) begin
      if (b == hdr_val || b == ftr_val || b == esc_val) begin
        stuff_byte(esc_val);
      end
      stuff_byte(b);
    end
    if (last) begin
      if (frame_dropped) begin
        queue_byte('0, 1'b1, 1'b1);
      end else begin
        queue_byte(hdr_val, 1'b0, 1'b0);
        queue_byte(BYTE_W'(stuffed_len), 1'b0, 1'b0);
        for (i = 0; i < stuffed_len; i++) begin
          queue_byte(stuffed_bytes[IDX_W'(i)], 1'b0, 1'b0);
        end
        queue_byte(byte_sum, 1'b0, 1'b0);
        queue_byte(ftr_val, 1'b1, 1'b0);
      end
      clear_frame();
    end
  endfunction

  // Follow writes, payload requests and frame requests at each rising edge.
  always @(posedge clk) begin : watch
    frame_byte_t want;
    if (!rst_n) begin
      hdr_val = HEADER_RST;
      ftr_val = FOOTER_RST;
      esc_val = ESCAPE_RST;
      clear_frame();
      frame_expect_q.delete();
      fail_count = 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_HEADER: hdr_val = cfg_wdata;
          CFG_FOOTER: ftr_val = cfg_wdata;
          CFG_ESCAPE: esc_val = cfg_wdata;
          default: ;
        endcase
      end
      if (in_tvalid && in_tready) begin
        encode_payload(in_tdata, in_tuser, in_tlast);
      end
      if (out_tvalid && out_tready) begin
        if (frame_expect_q.size() == 0) begin
          $error("unexpected frame byte: frame_byte %0d frame_end %0b too_long %0b",
                 out_tdata, out_tlast, out_tuser);
          fail_count++;
        end else begin
          want = frame_expect_q.pop_front();
          if (out_tdata !== want.frame_byte) begin
            $error("frame_byte: expected %0d, actual %0d", want.frame_byte, out_tdata);
            fail_count++;
          end
          if (out_tlast !== want.frame_end) begin
            $error("frame_end: expected %0b, actual %0b", want.frame_end, out_tlast);
            fail_count++;
          end
          if (out_tuser !== want.too_long) begin
            $error("too_long: expected %0b, actual %0b", want.too_long, out_tuser);
            fail_count++;
          end
        end
      end
    end
    pending = frame_expect_q.size();
  end

endmodule

@@ tb/sv/tb_byte_stuffed_frame_encoder.sv @@
// ----------------------------------------------------------------------------
// tb_byte_stuffed_frame_encoder
// Stimulus and verdict for the byte-stuffed frame encoder.
// ----------------------------------------------------------------------------
// Sends short directed frames (empty payload, idle requests, extreme bytes,
// each escaped value), frames at the store limit, and then random frames
// under several register settings. Both channels idle at random between
// requests, with stretches at full rate. The checker beside the block
// predicts and compares; this module only drives and decides the outcome.
module tb_byte_stuffed_frame_encoder;
  timeunit 1ns;
  timeprecision 1ps;

  import bsfe_pkg::*;

  localparam int STALL_LIMIT = 1000;
  localparam int PHASE_REQS  = 30;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [BYTE_W-1:0]    cfg_wdata;
  logic                 in_tvalid;
  logic                 in_tready;
  logic [7:0]           in_tdata;   // [7:0] payload_byte
  logic                 in_tuser;   // [0] has_byte
  logic                 in_tlast;   // end_of_payload
  logic                 out_tvalid;
  logic                 out_tready;
  logic [7:0]           out_tdata;  // [7:0] frame_byte
  logic                 out_tuser;  // [0] too_long
  logic                 out_tlast;  // frame_end

  int fail_count;
  int pending;
  int idle_cycles;
  int req_count;
  bit src_burst;
  bit sink_burst;

  // Register values last written, used to aim bytes at the escaped values.
  logic [BYTE_W-1:0] cur_hdr;
  logic [BYTE_W-1:0] cur_ftr;
  logic [BYTE_W-1:0] cur_esc;

  always #1 clk = ~clk;

  byte_stuffed_frame_encoder i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  bsfe_frame_checker i_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .fail_count (fail_count),
    .pending    (pending)
  );

  // Drive one payload request after a random gap and wait for its acceptance.
  // Entered and left at a falling edge; tvalid stays high on exit.
  task automatic send_req(logic [7:0] b, logic has_byte, logic last);
    int gap;
    gap = src_burst ? 0 : $urandom_range(0, 6);
    repeat (gap) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    in_tuser  <= has_byte;
    in_tlast  <= last;
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
    if (has_byte || last) begin
      req_count++;
    end
  endtask

  // Let the encoder go idle: no request pending and every frame byte out.
  task automatic drain();
    in_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [BYTE_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
    case (idx)
      CFG_HEADER: cur_hdr = val;
      CFG_FOOTER: cur_ftr = val;
      CFG_ESCAPE: cur_esc = val;
      default: ;
    endcase
  endtask

  // A random byte that needs no escaping under the current registers.
  function automatic logic [7:0] plain_byte();
    logic [7:0] b;
    do b = 8'($urandom_range(0, 255));
    while (b == cur_hdr || b == cur_ftr || b == cur_esc);
    return b;
  endfunction

  // A random byte, often one of the escaped values.
  function automatic logic [7:0] any_byte();
    case ($urandom_range(0, 7))
      0: return cur_hdr;
      1: return cur_ftr;
      2: return cur_esc;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // One frame of len payload bytes with random idle requests in between.
  task automatic run_frame(int len);
    bit end_apart;
    int i;
    src_burst = ($urandom_range(0, 3) == 0);
    end_apart = (len == 0) || ($urandom_range(0, 3) == 0);
    for (i = 0; i < len; i++) begin
      if ($urandom_range(0, 9) == 0) begin
        send_req(8'($urandom_range(0, 255)), 1'b0, 1'b0);
      end
      send_req(any_byte(), 1'b1, (i == len - 1) && !end_apart);
    end
    if (end_apart) begin
      send_req(8'($urandom_range(0, 255)), 1'b0, 1'b1);
    end
  endtask

  // Plain bytes up to the store limit, optionally closed by an escaped byte.
  task automatic run_long_frame(int plain_n, bit close_escaped);
    int i;
    src_burst = 1'b0;
    for (i = 0; i < plain_n; i++) begin
      send_req(plain_byte(), 1'b1, !close_escaped && (i == plain_n - 1));
    end
    if (close_escaped) begin
      send_req(any_byte() == cur_ftr ? cur_ftr : cur_esc, 1'b1, 1'b1);
    end
  endtask

  // Random frames, mostly short, some near the store limit.
  task automatic run_random_phase();
    int start;
    int pick;
    start = req_count;
    while (req_count - start < PHASE_REQS) begin
      pick = $urandom_range(0, 9);
      if (pick == 0) begin
        run_frame($urandom_range(40, 48));
      end else if (pick < 3) begin
        run_frame($urandom_range(9, 24));
      end else begin
        run_frame($urandom_range(0, 8));
      end
    end
  endtask

  // Sink side: a random stall before each frame byte, with bursts at full rate.
  initial begin
    int stall;
    out_tready = 1'b0;
    sink_burst = 1'b0;
    wait (rst_n === 1'b1);
    @(negedge clk);
    forever begin
      if ($urandom_range(0, 31) == 0) begin
        sink_burst = ~sink_burst;
      end
      stall = sink_burst ? 0 : $urandom_range(0, 6);
      repeat (stall) begin
        out_tready <= 1'b0;
        @(negedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
      @(negedge clk);
    end
  end

  // Watchdog on cycles without any accepted request.
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == STALL_LIMIT) begin
      $display("FAILED: results differ");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Main stimulus sequence.
  initial begin
    int p;
    rst_n       = 1'b0;
    cfg_we      = 1'b0;
    cfg_index   = '0;
    cfg_wdata   = '0;
    in_tvalid   = 1'b0;
    in_tdata    = '0;
    in_tuser    = 1'b0;
    in_tlast    = 1'b0;
    idle_cycles = 0;
    req_count   = 0;
    src_burst   = 1'b0;
    cur_hdr     = HEADER_RST;
    cur_ftr     = FOOTER_RST;
    cur_esc     = ESCAPE_RST;
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed frames under the reset register values.
    send_req(8'h00, 1'b0, 1'b1);
    send_req(8'h5A, 1'b0, 1'b0);
    send_req(8'h00, 1'b1, 1'b0);
    send_req(8'hFF, 1'b1, 1'b0);
    send_req(cur_hdr, 1'b1, 1'b0);
    send_req(cur_ftr, 1'b1, 1'b0);
    send_req(cur_esc, 1'b1, 1'b0);
    send_req(8'hA5, 1'b0, 1'b0);
    send_req(8'h55, 1'b1, 1'b1);
    send_req(8'hAA, 1'b1, 1'b1);
    send_req(8'h01, 1'b1, 1'b0);
    send_req(8'hFE, 1'b0, 1'b1);

    // Store limit: one byte short, an escape pair landing on the limit,
    // and an escape pair crossing it.
    run_long_frame(FRAME_BUF_LEN - 1, 1'b0);
    run_long_frame(FRAME_BUF_LEN - 2, 1'b1);
    run_long_frame(FRAME_BUF_LEN - 1, 1'b1);
    run_random_phase();

    // Further register settings, extremes first.
    for (p = 1; p <= 5; p++) begin
      drain();
      case (p)
        1: begin
          write_reg(CFG_HEADER, 8'h00);
          write_reg(CFG_FOOTER, 8'hFF);
          write_reg(CFG_ESCAPE, 8'h01);
        end
        2: begin
          write_reg(CFG_HEADER, 8'hFF);
          write_reg(CFG_FOOTER, 8'h00);
          write_reg(CFG_ESCAPE, 8'hFF);
          write_reg(CFG_UNUSED, 8'($urandom_range(0, 255)));
        end
        4: begin
          write_reg(CFG_HEADER, 8'h7E);
          write_reg(CFG_FOOTER, 8'h7E);
          write_reg(CFG_ESCAPE, 8'h7E);
        end
        default: begin
          write_reg(CFG_HEADER, 8'($urandom_range(0, 255)));
          write_reg(CFG_FOOTER, 8'($urandom_range(0, 255)));
          write_reg(CFG_ESCAPE, 8'($urandom_range(0, 255)));
        end
      endcase
      run_random_phase();
    end

    drain();
    if (fail_count == 0 && pending == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
